>>> hw/rtl/esc_pkg.sv
// esc_pkg: shared types, character codes and helpers for the expression syntax checker
// no dependencies; used by esc_next and expression_syntax_checker
package esc_pkg;

	typedef enum logic [2:0] {
		M_OPERAND       = 3'd0,
		M_INTEGER       = 3'd1,
		M_AFTER_DOT     = 3'd2,
		M_FRACTION      = 3'd3,
		M_AFTER_OPERAND = 3'd4,
		M_EQ_EXPECTED   = 3'd5
	} esc_mode_t;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_EQ    = 3'd1,
		ERR_PAREN = 3'd2,
		ERR_SYM   = 3'd3,
		ERR_DOT   = 3'd4,
		ERR_EXTRA = 3'd5,
		ERR_DEPTH = 3'd6
	} esc_err_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_OR    = 8'h7C;
	localparam logic [7:0] CH_AND   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	localparam int unsigned POS_W = 16;

	typedef struct packed {
		esc_mode_t        parse_mode;
		esc_err_t         latched_error;
		logic [POS_W-1:0] latched_position;
		logic [POS_W-1:0] char_count;
	} esc_state_t;

	typedef struct packed {
		logic             emit;
		logic             verdict_ok;
		esc_err_t         error_code;
		logic [POS_W-1:0] error_position;
	} esc_result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
	endfunction

endpackage

>>> hw/rtl/esc_in_stage.sv
// esc_in_stage: input register of the checker, holds one accepted character transaction
// depends on nothing but the clock and reset
module esc_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] symbol,
	input  logic       last,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] symbol_s1,
	output logic       last_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			symbol_s1 <= symbol;
			last_s1   <= last;
		end
	end

endmodule

>>> hw/rtl/esc_next.sv
// esc_next: next-state and verdict logic for one character of the expression
// depends on esc_pkg
module esc_next #(
	parameter int unsigned MAX_DEPTH = 255,
	parameter int unsigned DEPTH_W   = 8,
	parameter logic [esc_pkg::POS_W-1:0] COUNT_CAP = 16'hFFFF
) (
	input  esc_pkg::esc_state_t  cur,
	input  logic [DEPTH_W-1:0]   depth,
	input  logic [7:0]           symbol,
	input  logic                 last,
	output esc_pkg::esc_state_t  nxt,
	output logic [DEPTH_W-1:0]   depth_nxt,
	output esc_pkg::esc_result_t res
);

	logic [esc_pkg::POS_W-1:0] count1;
	logic                      is_end;
	esc_pkg::esc_mode_t        mode_n;
	logic [DEPTH_W-1:0]        depth_n;
	logic                      raise;
	esc_pkg::esc_err_t         rcode;
	logic                      ao;
	esc_pkg::esc_err_t         fcode;
	esc_pkg::esc_err_t         err_fin;
	logic [esc_pkg::POS_W-1:0] pos_fin;

	assign count1 = (!last && (cur.char_count < COUNT_CAP)) ?
		cur.char_count + 1'b1 : cur.char_count;
	assign is_end = last || (symbol == esc_pkg::CH_NUL);

	always_comb begin
		mode_n  = cur.parse_mode;
		depth_n = depth;
		raise   = 1'b0;
		rcode   = esc_pkg::ERR_NONE;
		ao      = 1'b0;
		case (cur.parse_mode)
			esc_pkg::M_OPERAND: begin
				if (esc_pkg::is_letter(symbol)) begin
					mode_n = esc_pkg::M_AFTER_OPERAND;
				end else if (esc_pkg::is_digit(symbol)) begin
					mode_n = esc_pkg::M_INTEGER;
				end else if (symbol == esc_pkg::CH_LPAR) begin
					if (depth == DEPTH_W'(MAX_DEPTH)) begin
						raise = 1'b1;
						rcode = esc_pkg::ERR_DEPTH;
					end else begin
						depth_n = depth + 1'b1;
					end
				end else if (symbol != esc_pkg::CH_BANG) begin
					raise = 1'b1;
					rcode = esc_pkg::ERR_SYM;
				end
			end
			esc_pkg::M_INTEGER: begin
				if (symbol == esc_pkg::CH_DOT) begin
					mode_n = esc_pkg::M_AFTER_DOT;
				end else if (!esc_pkg::is_digit(symbol)) begin
					ao = 1'b1;
				end
			end
			esc_pkg::M_AFTER_DOT: begin
				if (esc_pkg::is_digit(symbol)) begin
					mode_n = esc_pkg::M_FRACTION;
				end else begin
					raise = 1'b1;
					rcode = esc_pkg::ERR_DOT;
				end
			end
			esc_pkg::M_FRACTION: begin
				if (!esc_pkg::is_digit(symbol)) begin
					ao = 1'b1;
				end
			end
			esc_pkg::M_AFTER_OPERAND: begin
				ao = 1'b1;
			end
			default: begin
				if (symbol == esc_pkg::CH_EQ) begin
					mode_n = esc_pkg::M_OPERAND;
				end else begin
					raise = 1'b1;
					rcode = esc_pkg::ERR_EQ;
				end
			end
		endcase
		if (ao) begin
			case (symbol) inside
				esc_pkg::CH_OR, esc_pkg::CH_AND, esc_pkg::CH_LT, esc_pkg::CH_GT,
				esc_pkg::CH_PLUS, esc_pkg::CH_MINUS, esc_pkg::CH_STAR,
				esc_pkg::CH_SLASH: begin
					mode_n = esc_pkg::M_OPERAND;
				end
				esc_pkg::CH_EQ, esc_pkg::CH_BANG: begin
					mode_n = esc_pkg::M_EQ_EXPECTED;
				end
				esc_pkg::CH_RPAR: begin
					if (depth != '0) begin
						depth_n = depth - 1'b1;
						mode_n  = esc_pkg::M_AFTER_OPERAND;
					end else begin
						raise = 1'b1;
						rcode = esc_pkg::ERR_EXTRA;
					end
				end
				default: begin
					raise = 1'b1;
					rcode = (depth != '0) ? esc_pkg::ERR_PAREN : esc_pkg::ERR_EXTRA;
				end
			endcase
		end
	end

	always_comb begin
		case (cur.parse_mode)
			esc_pkg::M_OPERAND:     fcode = esc_pkg::ERR_SYM;
			esc_pkg::M_AFTER_DOT:   fcode = esc_pkg::ERR_DOT;
			esc_pkg::M_EQ_EXPECTED: fcode = esc_pkg::ERR_EQ;
			default: fcode = (depth != '0) ? esc_pkg::ERR_PAREN : esc_pkg::ERR_NONE;
		endcase
	end

	// first error wins, positioned at the updated count
	always_comb begin
		err_fin = cur.latched_error;
		pos_fin = cur.latched_position;
		if (cur.latched_error == esc_pkg::ERR_NONE) begin
			err_fin = is_end ? fcode : (raise ? rcode : esc_pkg::ERR_NONE);
			pos_fin = (err_fin != esc_pkg::ERR_NONE) ? count1 : cur.latched_position;
		end
	end

	always_comb begin
		res.emit           = is_end;
		res.verdict_ok     = (err_fin == esc_pkg::ERR_NONE);
		res.error_code     = err_fin;
		res.error_position = (err_fin == esc_pkg::ERR_NONE) ? count1 : pos_fin;
		if (is_end) begin
			nxt.parse_mode       = esc_pkg::M_OPERAND;
			nxt.latched_error    = esc_pkg::ERR_NONE;
			nxt.latched_position = '0;
			nxt.char_count       = '0;
			depth_nxt            = '0;
		end else begin
			nxt.parse_mode       = (cur.latched_error == esc_pkg::ERR_NONE) ?
				mode_n : cur.parse_mode;
			nxt.latched_error    = err_fin;
			nxt.latched_position = pos_fin;
			nxt.char_count       = count1;
			depth_nxt            = (cur.latched_error == esc_pkg::ERR_NONE) ? depth_n : depth;
		end
	end

endmodule

>>> hw/rtl/expression_syntax_checker.sv
// expression_syntax_checker: streaming syntax check, one character transaction per cycle unless an end stalls
// an end transaction passes through the input register, then its verdict is captured in the result register
// throughput: one transaction per cycle but for end stalls; the mode/depth/count update is combinational logic
// an end transaction waits in the input register only while the result register is full and out_ready is low
// reset: asynchronous active low, clears handshake state and the parse state to empty
// depends on esc_pkg, esc_in_stage, esc_next
module expression_syntax_checker #(
	parameter int unsigned      MAX_DEPTH  = 255,
	parameter longint unsigned  MAX_LENGTH = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  symbol,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        verdict_ok,
	output logic [2:0]  error_code,
	output logic [15:0] error_position
);

	localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam logic [esc_pkg::POS_W-1:0] COUNT_CAP =
		(MAX_LENGTH < 64'd65535) ? esc_pkg::POS_W'(MAX_LENGTH) : 16'hFFFF;

	logic                 valid_s1;
	logic [7:0]           symbol_s1;
	logic                 last_s1;
	logic                 end_s1;
	logic                 advance;
	esc_pkg::esc_state_t  state_q;
	esc_pkg::esc_state_t  state_nxt;
	logic [DEPTH_W-1:0]   depth_q;
	logic [DEPTH_W-1:0]   depth_nxt;
	esc_pkg::esc_result_t res;
	esc_pkg::esc_err_t    code_q;

	assign end_s1  = last_s1 || (symbol_s1 == esc_pkg::CH_NUL);
	assign advance = valid_s1 && (!end_s1 || !out_valid || out_ready);

	esc_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.symbol    (symbol),
		.last      (last),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.symbol_s1 (symbol_s1),
		.last_s1   (last_s1)
	);

	esc_next #(
		.MAX_DEPTH (MAX_DEPTH),
		.DEPTH_W   (DEPTH_W),
		.COUNT_CAP (COUNT_CAP)
	) u_next (
		.cur       (state_q),
		.depth     (depth_q),
		.symbol    (symbol_s1),
		.last      (last_s1),
		.nxt       (state_nxt),
		.depth_nxt (depth_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.parse_mode       <= esc_pkg::M_OPERAND;
			state_q.latched_error    <= esc_pkg::ERR_NONE;
			state_q.latched_position <= '0;
			state_q.char_count       <= '0;
			depth_q                  <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			depth_q <= depth_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && res.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			verdict_ok     <= res.verdict_ok;
			code_q         <= res.error_code;
			error_position <= res.error_position;
		end
	end

	assign error_code = code_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_DEPTH))
		else $error("nesting depth above limit");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.char_count <= COUNT_CAP)
		else $error("character count above cap");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.emit) |=> (state_q.char_count == '0 && depth_q == '0
			&& state_q.latched_error == esc_pkg::ERR_NONE && out_valid))
		else $error("state not cleared after verdict");

	a_verdict_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict_ok == (code_q == esc_pkg::ERR_NONE)))
		else $error("verdict and error code disagree");

endmodule
